[hdl/assert_macros.svh]
// Assertion macros shared by the list modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("list assertion failed");

// Next-cycle implication, checked outside reset.
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("list assertion failed");

`endif

[hdl/alwc_pkg.sv]
// Package for the array list with cursor: sizes, codes, FSM states and the
// command/status structs between controller and datapath. No dependencies.
package alwc_pkg;

	localparam int DEPTH   = 128;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int WORD_W  = 32;
	localparam int ENTRY_W = 8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIRST  = 2'd1,
		OP_NEXT   = 2'd2,
		OP_REMOVE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NO_ENTRY = 2'd2,
		ST_NO_CUR   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RDWAIT,
		S_RM_CAP,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    take_item;
		logic    res_we;
		status_t res_status;
		logic    do_insert;
		logic    do_first;
		logic    do_next;
		logic    rm_start;
		logic    capture_rd;
		logic    shift_step;
		logic    rm_commit;
		logic    load_out;
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    full;
		logic    nonempty;
		logic    next_ok;
		logic    cur_ok;
		logic    shift_done;
		logic    out_free;
	} sts_t;

endpackage

[hdl/alwc_ctrl.sv]
// Controller FSM for the array list: sequences each item through decide,
// read, shift and result phases. Depends on alwc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module alwc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  alwc_pkg::sts_t  sts,
	output alwc_pkg::cmd_t  cmd
);

	alwc_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alwc_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			alwc_pkg::S_IDLE: begin
				if (in_valid) state_nxt = alwc_pkg::S_EXEC;
			end
			alwc_pkg::S_EXEC: begin
				unique case (sts.op)
					alwc_pkg::OP_INSERT: state_nxt = alwc_pkg::S_DONE;
					alwc_pkg::OP_FIRST:
						state_nxt = sts.nonempty ? alwc_pkg::S_RDWAIT : alwc_pkg::S_DONE;
					alwc_pkg::OP_NEXT:
						state_nxt = sts.next_ok ? alwc_pkg::S_RDWAIT : alwc_pkg::S_DONE;
					alwc_pkg::OP_REMOVE:
						state_nxt = sts.cur_ok ? alwc_pkg::S_RM_CAP : alwc_pkg::S_DONE;
					default: state_nxt = alwc_pkg::S_DONE;
				endcase
			end
			alwc_pkg::S_RDWAIT: state_nxt = alwc_pkg::S_DONE;
			alwc_pkg::S_RM_CAP: state_nxt = alwc_pkg::S_SHIFT;
			alwc_pkg::S_SHIFT: begin
				if (sts.shift_done) state_nxt = alwc_pkg::S_DONE;
			end
			alwc_pkg::S_DONE: begin
				if (sts.out_free) state_nxt = alwc_pkg::S_IDLE;
			end
			default: state_nxt = alwc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = (state_q != alwc_pkg::S_IDLE);
		unique case (state_q)
			alwc_pkg::S_IDLE: cmd.take_item = in_valid;
			alwc_pkg::S_EXEC: begin
				cmd.res_we = 1'b1;
				unique case (sts.op)
					alwc_pkg::OP_INSERT: begin
						if (sts.full) begin
							cmd.res_status = alwc_pkg::ST_FULL;
						end else begin
							cmd.res_status = alwc_pkg::ST_OK;
							cmd.do_insert  = 1'b1;
						end
					end
					alwc_pkg::OP_FIRST: begin
						if (sts.nonempty) begin
							cmd.res_status = alwc_pkg::ST_OK;
							cmd.do_first   = 1'b1;
						end else begin
							cmd.res_status = alwc_pkg::ST_NO_ENTRY;
						end
					end
					alwc_pkg::OP_NEXT: begin
						if (sts.next_ok) begin
							cmd.res_status = alwc_pkg::ST_OK;
							cmd.do_next    = 1'b1;
						end else begin
							cmd.res_status = alwc_pkg::ST_NO_ENTRY;
						end
					end
					alwc_pkg::OP_REMOVE: begin
						if (sts.cur_ok) begin
							cmd.res_status = alwc_pkg::ST_OK;
							cmd.rm_start   = 1'b1;
						end else begin
							cmd.res_status = alwc_pkg::ST_NO_CUR;
						end
					end
					default: cmd.res_status = alwc_pkg::ST_OK;
				endcase
			end
			alwc_pkg::S_RDWAIT: cmd.capture_rd = 1'b1;
			alwc_pkg::S_RM_CAP: begin
				cmd.capture_rd = 1'b1;
				cmd.shift_step = 1'b1;
			end
			alwc_pkg::S_SHIFT: begin
				if (sts.shift_done) begin
					cmd.rm_commit = 1'b1;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			alwc_pkg::S_DONE: cmd.load_out = sts.out_free;
			default: cmd = '0;
		endcase
	end

	`AST_NEXT(a_take_exec, cmd.take_item, state_q == alwc_pkg::S_EXEC)
	`AST_IMPL(a_one_mem_op, cmd.do_insert, !cmd.shift_step && !cmd.rm_start)

endmodule

[hdl/alwc_datapath.sv]
// Datapath for the array list: entry memory, count, cursor, shift pointers
// and the result register. Depends on alwc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module alwc_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          opcode,
	input  logic signed [alwc_pkg::WORD_W-1:0]  data_in,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [1:0]                          status,
	output logic signed [alwc_pkg::WORD_W-1:0]  data_out,
	output logic [alwc_pkg::ENTRY_W-1:0]        entry_count,
	input  alwc_pkg::cmd_t                      cmd,
	output alwc_pkg::sts_t                      sts
);

	logic [alwc_pkg::WORD_W-1:0] mem [alwc_pkg::DEPTH];

	alwc_pkg::opcode_t           op_q;
	logic [alwc_pkg::WORD_W-1:0] data_q;
	logic [alwc_pkg::CNT_W-1:0]  count_q;
	logic                        cur_vld_q;
	logic [alwc_pkg::IDX_W-1:0]  cur_idx_q;
	logic [alwc_pkg::WORD_W-1:0] rd_data_q;
	logic [alwc_pkg::CNT_W-1:0]  rd_ptr_q;
	logic [alwc_pkg::IDX_W-1:0]  wr_ptr_q;
	logic                        wr_pend_q;
	alwc_pkg::status_t           res_status_q;
	logic [alwc_pkg::WORD_W-1:0] res_data_q;
	logic                        out_valid_q;
	alwc_pkg::status_t           out_status_q;
	logic [alwc_pkg::WORD_W-1:0] out_data_q;
	logic [alwc_pkg::ENTRY_W-1:0] out_count_q;

	logic [alwc_pkg::CNT_W-1:0]  cur_ext;
	logic [alwc_pkg::CNT_W-1:0]  next_pos;
	logic                        rd_more;
	logic [alwc_pkg::IDX_W-1:0]  rd_addr;

	assign cur_ext  = alwc_pkg::CNT_W'(cur_idx_q);
	assign next_pos = cur_vld_q ? cur_ext + 1'b1 : '0;
	assign rd_more  = (rd_ptr_q < count_q);

	assign sts.op         = op_q;
	assign sts.full       = (count_q == alwc_pkg::CNT_W'(alwc_pkg::DEPTH));
	assign sts.nonempty   = (count_q != '0);
	assign sts.next_ok    = (next_pos < count_q);
	assign sts.cur_ok     = cur_vld_q && (cur_ext < count_q);
	assign sts.shift_done = !rd_more && !wr_pend_q;
	assign sts.out_free   = !out_valid_q || !out_stall;

	// read address: first entry, next entry, removed entry or shift source
	always_comb begin
		rd_addr = rd_ptr_q[alwc_pkg::IDX_W-1:0];
		if (cmd.do_first) begin
			rd_addr = '0;
		end else if (cmd.do_next) begin
			rd_addr = next_pos[alwc_pkg::IDX_W-1:0];
		end else if (cmd.rm_start) begin
			rd_addr = cur_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (cmd.do_insert) begin
			mem[count_q[alwc_pkg::IDX_W-1:0]] <= data_q;
		end else if (cmd.shift_step && wr_pend_q) begin
			mem[wr_ptr_q] <= rd_data_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			op_q   <= alwc_pkg::opcode_t'(opcode);
			data_q <= data_in;
		end
		if (cmd.res_we) begin
			res_status_q <= cmd.res_status;
			res_data_q   <= '0;
		end else if (cmd.capture_rd) begin
			res_data_q <= rd_data_q;
		end
		if (cmd.rm_start) begin
			rd_ptr_q <= cur_ext + 1'b1;
			wr_ptr_q <= cur_idx_q;
		end else if (cmd.shift_step) begin
			if (rd_more) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_pend_q) wr_ptr_q <= wr_ptr_q + 1'b1;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_data_q   <= res_data_q;
			out_count_q  <= alwc_pkg::ENTRY_W'(count_q);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cur_vld_q   <= 1'b0;
			cur_idx_q   <= '0;
			wr_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.do_insert) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.rm_commit) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.do_first) begin
				cur_vld_q <= 1'b1;
				cur_idx_q <= '0;
			end else if (cmd.do_next) begin
				cur_vld_q <= 1'b1;
				cur_idx_q <= next_pos[alwc_pkg::IDX_W-1:0];
			end else if (cmd.rm_commit) begin
				if (cur_idx_q == '0) begin
					cur_vld_q <= 1'b0;
				end else begin
					cur_idx_q <= cur_idx_q - 1'b1;
				end
			end
			if (cmd.rm_start) begin
				wr_pend_q <= 1'b0;
			end else if (cmd.shift_step) begin
				wr_pend_q <= rd_more;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign data_out    = out_data_q;
	assign entry_count = out_count_q;

	`AST_IMPL(a_cursor_in_list, cur_vld_q, cur_ext < count_q)
	`AST_NEXT(a_insert_count, cmd.do_insert, count_q == $past(count_q) + 1'b1)
	`AST_IMPL(a_count_bound, 1'b1, count_q <= alwc_pkg::CNT_W'(alwc_pkg::DEPTH))

endmodule

[hdl/array_list_with_cursor_top.sv]
// Array list with cursor, top level: ordered list of signed words with insert,
// first, next and remove-at-cursor. Each item is taken in the idle state, then
// passes the decide state, for a successful first/next a read state, for a
// successful remove the capture and shift states, and then the result state.
// The entry shift on remove moves one word per cycle through the memory,
// reading and writing each step. The next item is taken only after the result
// is registered, so no new item is accepted before the last one is through.
// Reset clears count, cursor and result valid; entry storage is not cleared.
//
// Depends on alwc_pkg, alwc_ctrl and alwc_datapath.

module array_list_with_cursor_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel: one item per handshake
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          opcode,
	input  logic signed [alwc_pkg::WORD_W-1:0]  data_in,
	// result channel: held in an output register until taken
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic signed [alwc_pkg::WORD_W-1:0]  data_out,
	output logic [alwc_pkg::ENTRY_W-1:0]        entry_count
);

	// controller drives commands, datapath answers with decision flags
	alwc_pkg::cmd_t cmd;
	alwc_pkg::sts_t sts;

	// sequence each item: decide, read, shift, then hand the result over
	alwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold the entries, count, cursor and the registered result
	alwc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.opcode      (opcode),
		.data_in     (data_in),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.data_out    (data_out),
		.entry_count (entry_count),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

[sim/testbench.sv]
// Testbench for array_list_with_cursor_top: a directed table, then random insert/read/remove
// traffic, each result checked against a typed expectation or an in-bench model of the list and its cursor.
// Depends on alwc_pkg and the RTL under hdl.
`timescale 1ns / 100ps

module testbench;

	typedef logic signed [alwc_pkg::WORD_W-1:0] word_t;

	// One result item: what the block returns for each input item.
	typedef struct packed {
		alwc_pkg::status_t                 status;
		word_t                             data;
		logic [alwc_pkg::ENTRY_W-1:0]      count;
	} list_result_t;

	// One row of the directed table. Where 'typed' is set, the expected result is
	// written into the row; otherwise the list model supplies it.
	typedef struct packed {
		alwc_pkg::opcode_t  op;
		word_t              word;
		logic               typed;
		list_result_t       want;
	} table_row_t;

	localparam int DIR_ROWS     = 24;
	localparam int RANDOM_ITEMS = 1800;
	localparam int MAX_REPORTS  = 10;

	// Mode of a random phase: fill the list, drain it, or a bit of both.
	typedef enum int {
		MODE_GROW,
		MODE_SHRINK,
		MODE_MIXED
	} phase_mode_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [1:0]                    opcode = alwc_pkg::OP_INSERT;
	word_t                         data_in = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [1:0]                    status;
	word_t                         data_out;
	logic [alwc_pkg::ENTRY_W-1:0]  entry_count;

	// Model of the list: stored words, number held, cursor (-1 means no position).
	word_t  list_words [alwc_pkg::DEPTH];
	int     model_count = 0;
	int     list_cursor = -1;

	// Results still owed by the block, oldest first.
	list_result_t  pending_results [$];
	int            mismatch_count = 0;

	// Percentage of cycles in which each side holds off.
	int  in_idle_pct = 18;
	int  out_idle_pct = 18;

	// The directed table. It walks the special cases in order: reads and remove on
	// an empty list, the extreme words, next from no position, remove at the head
	// and the following next, next past the last entry, remove at the tail and in
	// the middle.
	table_row_t dir_rows [DIR_ROWS] = '{
		'{alwc_pkg::OP_NEXT, 32'h1234_5678, 1'b1, '{alwc_pkg::ST_NO_ENTRY, 32'h0, 8'd0}},
		'{alwc_pkg::OP_FIRST, 32'hFFFF_FFFF, 1'b1, '{alwc_pkg::ST_NO_ENTRY, 32'h0, 8'd0}},
		'{alwc_pkg::OP_REMOVE, 32'h8000_0000, 1'b1, '{alwc_pkg::ST_NO_CUR, 32'h0, 8'd0}},
		'{alwc_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{alwc_pkg::ST_OK, 32'h0, 8'd1}},
		'{alwc_pkg::OP_INSERT, 32'h8000_0000, 1'b1, '{alwc_pkg::ST_OK, 32'h0, 8'd2}},
		'{alwc_pkg::OP_INSERT, 32'h0000_0000, 1'b1, '{alwc_pkg::ST_OK, 32'h0, 8'd3}},
		'{alwc_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{alwc_pkg::ST_OK, 32'h0, 8'd4}},
		'{alwc_pkg::OP_INSERT, 32'h5A5A_5A5A, 1'b1, '{alwc_pkg::ST_OK, 32'h0, 8'd5}},
		'{alwc_pkg::OP_NEXT, 32'h0, 1'b1, '{alwc_pkg::ST_OK, 32'h7FFF_FFFF, 8'd5}},
		'{alwc_pkg::OP_NEXT, 32'h0, 1'b1, '{alwc_pkg::ST_OK, 32'h8000_0000, 8'd5}},
		'{alwc_pkg::OP_FIRST, 32'hDEAD_BEEF, 1'b1, '{alwc_pkg::ST_OK, 32'h7FFF_FFFF, 8'd5}},
		'{alwc_pkg::OP_REMOVE, 32'h0, 1'b1, '{alwc_pkg::ST_OK, 32'h7FFF_FFFF, 8'd4}},
		'{alwc_pkg::OP_REMOVE, 32'h0, 1'b1, '{alwc_pkg::ST_NO_CUR, 32'h0, 8'd4}},
		'{alwc_pkg::OP_NEXT, 32'h0, 1'b1, '{alwc_pkg::ST_OK, 32'h8000_0000, 8'd4}},
		'{alwc_pkg::OP_NEXT, 32'h0, 1'b0, '{alwc_pkg::ST_OK, 32'h0, 8'd0}},
		'{alwc_pkg::OP_NEXT, 32'h0, 1'b0, '{alwc_pkg::ST_OK, 32'h0, 8'd0}},
		'{alwc_pkg::OP_NEXT, 32'h0, 1'b0, '{alwc_pkg::ST_OK, 32'h0, 8'd0}},
		'{alwc_pkg::OP_NEXT, 32'h0, 1'b1, '{alwc_pkg::ST_NO_ENTRY, 32'h0, 8'd4}},
		'{alwc_pkg::OP_REMOVE, 32'h0, 1'b1, '{alwc_pkg::ST_OK, 32'h5A5A_5A5A, 8'd3}},
		'{alwc_pkg::OP_REMOVE, 32'h0, 1'b0, '{alwc_pkg::ST_OK, 32'h0, 8'd0}},
		'{alwc_pkg::OP_INSERT, 32'hA5A5_A5A5, 1'b0, '{alwc_pkg::ST_OK, 32'h0, 8'd0}},
		'{alwc_pkg::OP_REMOVE, 32'h0, 1'b0, '{alwc_pkg::ST_OK, 32'h0, 8'd0}},
		'{alwc_pkg::OP_FIRST, 32'h0, 1'b0, '{alwc_pkg::ST_OK, 32'h0, 8'd0}},
		'{alwc_pkg::OP_REMOVE, 32'h0, 1'b0, '{alwc_pkg::ST_OK, 32'h0, 8'd0}}
	};

	array_list_with_cursor_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.data_in     (data_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.data_out    (data_out),
		.entry_count (entry_count)
	);

	// 4 ns clock: two ns high, two ns low.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Apply one list operation to the model and return the result the block owes.
	function automatic list_result_t apply_list_op(input alwc_pkg::opcode_t op,
			input word_t word);
		list_result_t res;
		res.status = alwc_pkg::ST_OK;
		res.data = '0;
		case (op)
			alwc_pkg::OP_INSERT: begin
				if (model_count >= alwc_pkg::DEPTH) begin
					res.status = alwc_pkg::ST_FULL;
				end else begin
					list_words[model_count] = word;
					model_count++;
				end
			end
			alwc_pkg::OP_FIRST: begin
				if (model_count == 0) begin
					res.status = alwc_pkg::ST_NO_ENTRY;
				end else begin
					list_cursor = 0;
					res.data = list_words[0];
				end
			end
			alwc_pkg::OP_NEXT: begin
				// From no position this lands on entry 0, the same as first.
				if (list_cursor >= model_count - 1) begin
					res.status = alwc_pkg::ST_NO_ENTRY;
				end else begin
					list_cursor++;
					res.data = list_words[list_cursor];
				end
			end
			default: begin
				if (list_cursor < 0 || list_cursor >= model_count) begin
					res.status = alwc_pkg::ST_NO_CUR;
				end else begin
					res.data = list_words[list_cursor];
					// Close the gap, then step the cursor back (to -1 at the head).
					for (int i = list_cursor; i < model_count - 1; i++)
						list_words[i] = list_words[i + 1];
					model_count--;
					list_cursor--;
				end
			end
		endcase
		res.count = model_count[alwc_pkg::ENTRY_W-1:0];
		return res;
	endfunction

	// Offer one item on the input channel, idling at random first; on acceptance
	// update the model. A typed expectation, where given, replaces the model's.
	task automatic offer_item(input alwc_pkg::opcode_t op, input word_t word,
			input logic typed, input list_result_t typed_want);
		list_result_t model_want;
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		data_in <= word;
		@(posedge clk);
		// Hold the payload until an edge finds stall low.
		while (in_stall)
			@(posedge clk);
		model_want = apply_list_op(op, word);
		pending_results.push_back(typed ? typed_want : model_want);
	endtask

	// Random data word, with a fair share of the extremes.
	function automatic word_t pick_word();
		case ($urandom_range(15))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return word_t'($urandom);
		endcase
	endfunction

	// Opcode mix for each phase mode.
	function automatic alwc_pkg::opcode_t pick_opcode(input phase_mode_t mode);
		int roll;
		roll = $urandom_range(99);
		case (mode)
			MODE_GROW:
				return roll < 75 ? alwc_pkg::OP_INSERT
					: roll < 80 ? alwc_pkg::OP_FIRST
					: roll < 90 ? alwc_pkg::OP_NEXT : alwc_pkg::OP_REMOVE;
			MODE_SHRINK:
				return roll < 10 ? alwc_pkg::OP_INSERT
					: roll < 25 ? alwc_pkg::OP_FIRST
					: roll < 55 ? alwc_pkg::OP_NEXT : alwc_pkg::OP_REMOVE;
			default:
				return alwc_pkg::opcode_t'(roll % 4);
		endcase
	endfunction

	// Result side: check each accepted result against the oldest expectation, and
	// stall at random. Sampling happens before this edge's updates land.
	always @(posedge clk) begin : result_check
		list_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: status %0d data %0d count %0d",
						status, data_out, entry_count);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status || data_out !== want.data
						|| entry_count !== want.count) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: expected status %0d data %0d count %0d, %s",
							want.status, want.data, want.count,
							$sformatf("got status %0d data %0d count %0d",
								status, data_out, entry_count));
				end
			end
		end
		out_stall <= ($urandom_range(99) < out_idle_pct);
	end

	// Stimulus: reset, directed table, fill to capacity, random phases, drain.
	initial begin : stimulus
		phase_mode_t  mode;
		int           phase_left;
		list_result_t no_want;
		no_want = '{alwc_pkg::ST_OK, 32'h0000_0000, 8'd0};
		mode = MODE_GROW;
		phase_left = 0;

		// Hold reset, then release it on an edge.
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table.
		for (int r = 0; r < DIR_ROWS; r++)
			offer_item(dir_rows[r].op, dir_rows[r].word, dir_rows[r].typed,
				dir_rows[r].want);

		// Fill the list, try one insert too many, then remove at the head of a full
		// list so that every later entry has to move.
		while (model_count < alwc_pkg::DEPTH)
			offer_item(alwc_pkg::OP_INSERT, pick_word(), 1'b0, no_want);
		offer_item(alwc_pkg::OP_INSERT, 32'h1357_9BDF, 1'b1,
			'{alwc_pkg::ST_FULL, 32'h0000_0000, 8'(alwc_pkg::DEPTH)});
		offer_item(alwc_pkg::OP_FIRST, pick_word(), 1'b0, no_want);
		offer_item(alwc_pkg::OP_REMOVE, pick_word(), 1'b0, no_want);

		// Random phases of grow, shrink and mixed traffic.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				mode = phase_mode_t'($urandom_range(2));
				phase_left = $urandom_range(120, 20);
			end
			phase_left--;
			// Drop all idling on both sides for one long stretch.
			if (n == 700) begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end else if (n == 1000) begin
				in_idle_pct = 18;
				out_idle_pct = 18;
			end
			offer_item(pick_opcode(mode), pick_word(), 1'b0, no_want);
		end
		in_valid <= 1'b0;

		// Wait for every owed result, then long enough for a stray one to show up.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (alwc_pkg::DEPTH + 16) @(posedge clk);

		if (mismatch_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin : watchdog
		#8_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
